[rtl/epm_pkg.sv]
// ----------------------------------------------------------------------------
// Energy pulse meter package
// Shared constants, register map, controller states and the command, status
// and configuration structs used across the meter.
// ----------------------------------------------------------------------------
package epm_pkg;

   // reading length limit and arithmetic constants
   localparam int MAX_SAMPLES   = 64;
   localparam int ADC_W         = 10;
   localparam int ADC_MAX       = (1 << ADC_W) - 1;
   localparam int MV_FULL_SCALE = 5000;
   localparam int ADC_COUNTS    = 1025;
   localparam int MS_PER_HOUR   = 3600000;

   // field and state widths
   localparam int SUM_W     = $clog2(MAX_SAMPLES * ADC_MAX + 1);
   localparam int TAKEN_W   = $clog2(MAX_SAMPLES + 1);
   localparam int SPR_W     = 7;
   localparam int MV_W      = 13;
   localparam int EPC_W     = 8;
   localparam int WH_W      = 10;
   localparam int TIME_W    = 32;
   localparam int DIV_W     = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // bus widths
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 64;
   localparam int RSP_PAD = RSP_W - (MV_W + 1 + 1 + 1 + WH_W + 1 + DIV_W);
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 3;

   // register reset values
   localparam logic [SPR_W-1:0] SPR_RESET  = SPR_W'(5);
   localparam logic [MV_W-1:0]  LOW_RESET  = MV_W'(3500);
   localparam logic [MV_W-1:0]  HIGH_RESET = MV_W'(3900);
   localparam logic [EPC_W-1:0] EPC_RESET  = EPC_W'(6);
   localparam logic [WH_W-1:0]  WH_RESET   = WH_W'(10);

   // register map, word index = byte address / 4
   typedef enum logic [IDX_W-1:0] {
      REG_SAMPLES_PER_READING = 3'd0,
      REG_LOW_THRESHOLD       = 3'd1,
      REG_HIGH_THRESHOLD      = 3'd2,
      REG_EDGES_PER_COUNT     = 3'd3,
      REG_WH_PER_COUNT        = 3'd4
   } epm_reg_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_MV_START,
      ST_MV_WAIT,
      ST_EVAL,
      ST_PW_START,
      ST_PW_WAIT,
      ST_OUT
   } epm_state_type;

   typedef struct packed {
      logic [SPR_W-1:0] samples_per_reading;
      logic [MV_W-1:0]  low_threshold_mv;
      logic [MV_W-1:0]  high_threshold_mv;
      logic [EPC_W-1:0] edges_per_count;
      logic [WH_W-1:0]  wh_per_count;
   } epm_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // input word taken this cycle
      logic mul;        // form reading numerator and denominator
      logic div_start;  // launch the divider
      logic div_pw;     // divider operands: 0 reading, 1 power
      logic eval;       // threshold, edge and count update
      logic pw_store;   // capture power quotient
      logic out_load;   // load result register
   } epm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic reading_done;  // the offered sample completes a reading
      logic div_busy;
      logic power_div;     // this reading needs the power division
      logic out_free;      // result register can take a new word
   } epm_sts_type;

endpackage

[rtl/epm_csr.sv]
// ----------------------------------------------------------------------------
// Energy pulse meter register file
// APB-style configuration registers with reset values and read-back.
// ----------------------------------------------------------------------------
module epm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [epm_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [epm_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [epm_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output epm_pkg::epm_cfg_type        cfg
);

   epm_pkg::epm_cfg_type cfg_ff, cfg_in;
   epm_pkg::epm_reg_type idx;
   logic                 wr_en;

   assign idx        = epm_pkg::epm_reg_type'(csr_paddr[epm_pkg::ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            epm_pkg::REG_SAMPLES_PER_READING:
               cfg_in.samples_per_reading = csr_pwdata[epm_pkg::SPR_W-1:0];
            epm_pkg::REG_LOW_THRESHOLD:
               cfg_in.low_threshold_mv = csr_pwdata[epm_pkg::MV_W-1:0];
            epm_pkg::REG_HIGH_THRESHOLD:
               cfg_in.high_threshold_mv = csr_pwdata[epm_pkg::MV_W-1:0];
            epm_pkg::REG_EDGES_PER_COUNT:
               cfg_in.edges_per_count = csr_pwdata[epm_pkg::EPC_W-1:0];
            epm_pkg::REG_WH_PER_COUNT:
               cfg_in.wh_per_count = csr_pwdata[epm_pkg::WH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_per_reading <= epm_pkg::SPR_RESET;
         cfg_ff.low_threshold_mv    <= epm_pkg::LOW_RESET;
         cfg_ff.high_threshold_mv   <= epm_pkg::HIGH_RESET;
         cfg_ff.edges_per_count     <= epm_pkg::EPC_RESET;
         cfg_ff.wh_per_count        <= epm_pkg::WH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read-back
   always_comb begin
      csr_prdata = '0;
      case (idx)
         epm_pkg::REG_SAMPLES_PER_READING:
            csr_prdata = epm_pkg::DATA_W'(cfg_ff.samples_per_reading);
         epm_pkg::REG_LOW_THRESHOLD:
            csr_prdata = epm_pkg::DATA_W'(cfg_ff.low_threshold_mv);
         epm_pkg::REG_HIGH_THRESHOLD:
            csr_prdata = epm_pkg::DATA_W'(cfg_ff.high_threshold_mv);
         epm_pkg::REG_EDGES_PER_COUNT:
            csr_prdata = epm_pkg::DATA_W'(cfg_ff.edges_per_count);
         epm_pkg::REG_WH_PER_COUNT:
            csr_prdata = epm_pkg::DATA_W'(cfg_ff.wh_per_count);
         default: csr_prdata = '0;
      endcase
   end

endmodule

[rtl/epm_div.sv]
// ----------------------------------------------------------------------------
// Energy pulse meter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module epm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [epm_pkg::DIV_W-1:0]  dividend,
   input  logic [epm_pkg::DIV_W-1:0]  divisor,
   output logic                       busy,
   output logic [epm_pkg::DIV_W-1:0]  quotient
);

   logic [epm_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [epm_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [epm_pkg::DIV_W-1:0]     dvs_ff, dvs_in;
   logic [epm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic [epm_pkg::DIV_W:0]       shifted;
   logic [epm_pkg::DIV_W:0]       diff;
   logic                          fits;

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[epm_pkg::DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = ~diff[epm_pkg::DIV_W];

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = epm_pkg::DIV_CNT_W'(epm_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[epm_pkg::DIV_W-1:0] : shifted[epm_pkg::DIV_W-1:0];
         quo_in  = {quo_ff[epm_pkg::DIV_W-2:0], fits};
         cnt_in  = cnt_ff - epm_pkg::DIV_CNT_W'(1);
         busy_in = (cnt_ff != epm_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         quo_ff <= '0;
         dvs_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         dvs_ff <= dvs_in;
      end
   end

   // a launch always makes the unit busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   // an idle divider holds its quotient
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !start) |=> $stable(quo_ff))
      else $error("quotient moved while idle");

endmodule

[rtl/epm_dp.sv]
// ----------------------------------------------------------------------------
// Energy pulse meter datapath
// Sample accumulation, millivolt and power arithmetic, hysteresis and count
// state, and the result register.
// ----------------------------------------------------------------------------
module epm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  epm_pkg::epm_cfg_type          cfg,
   input  epm_pkg::epm_cmd_type          cmd,
   output epm_pkg::epm_sts_type          sts,
   input  logic                          in_kind,
   input  logic [epm_pkg::ADC_W-1:0]     in_raw,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [epm_pkg::RSP_W-1:0]     rsp_tdata
);

   // architectural state
   logic [epm_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [epm_pkg::TAKEN_W-1:0] taken_ff, taken_in;
   logic [epm_pkg::MV_W-1:0]    last_out_ff, last_out_in;
   logic [epm_pkg::EPC_W-1:0]   edge_cnt_ff, edge_cnt_in;
   logic [epm_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [epm_pkg::TIME_W-1:0]  last_cnt_ff, last_cnt_in;
   logic                        have_prev_ff, have_prev_in;
   logic                        led_ff, led_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [epm_pkg::DIV_W-1:0]   num_ff, den_ff, pw_num_ff, elapsed_ff;
   logic [epm_pkg::DIV_W-1:0]   power_ff;
   logic [epm_pkg::MV_W-1:0]    mv_ff;
   logic [epm_pkg::WH_W-1:0]    energy_ff;
   logic                        edge_ff, done_ff, pvalid_ff;
   logic [epm_pkg::RSP_W-1:0]   rsp_data_ff;

   logic [epm_pkg::TAKEN_W-1:0] n_eff;
   logic [epm_pkg::TAKEN_W:0]   taken_next;
   logic [epm_pkg::EPC_W-1:0]   epc_eff, edge_cnt_inc;
   logic [epm_pkg::MV_W-1:0]    mv_c;
   logic [epm_pkg::TIME_W-1:0]  elapsed_c;
   logic                        edge_c, done_c, in_band;
   logic                        div_busy;
   logic [epm_pkg::DIV_W-1:0]   div_quo, div_dvd, div_dvs;

   // effective reading length: zero acts as one, clamp at the maximum
   always_comb begin
      if (cfg.samples_per_reading == '0) begin
         n_eff = epm_pkg::TAKEN_W'(1);
      end else if (32'(cfg.samples_per_reading) > 32'(epm_pkg::MAX_SAMPLES)) begin
         n_eff = epm_pkg::TAKEN_W'(epm_pkg::MAX_SAMPLES);
      end else begin
         n_eff = epm_pkg::TAKEN_W'(cfg.samples_per_reading);
      end
   end

   assign taken_next = {1'b0, taken_ff} + (epm_pkg::TAKEN_W + 1)'(1);

   // reading evaluation terms
   assign mv_c         = div_quo[epm_pkg::MV_W-1:0];
   assign epc_eff      = (cfg.edges_per_count == '0) ? epm_pkg::EPC_W'(1)
                                                    : cfg.edges_per_count;
   assign edge_cnt_inc = edge_cnt_ff + epm_pkg::EPC_W'(1);
   assign edge_c       = (mv_c > cfg.high_threshold_mv) &&
                         (last_out_ff < cfg.low_threshold_mv);
   assign done_c       = edge_c && ((edge_cnt_inc >= epc_eff) ||
                                    (edge_cnt_inc == '0));
   assign in_band      = (mv_c > cfg.low_threshold_mv) &&
                         (mv_c < cfg.high_threshold_mv);
   assign elapsed_c    = now_ff - last_cnt_ff;

   // status to controller
   always_comb begin
      sts.reading_done = !in_kind && ({1'b0, n_eff} <= taken_next);
      sts.div_busy     = div_busy;
      sts.power_div    = done_c && have_prev_ff && (elapsed_c != '0);
      sts.out_free     = !rsp_valid_ff || rsp_tready;
   end

   // shared divider operands
   assign div_dvd = cmd.div_pw ? pw_num_ff : (num_ff + den_ff - epm_pkg::DIV_W'(1));
   assign div_dvs = cmd.div_pw ? elapsed_ff : den_ff;

   epm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // state update
   always_comb begin
      sum_in       = sum_ff;
      taken_in     = taken_ff;
      last_out_in  = last_out_ff;
      edge_cnt_in  = edge_cnt_ff;
      now_in       = now_ff;
      last_cnt_in  = last_cnt_ff;
      have_prev_in = have_prev_ff;
      led_in       = led_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.accept) begin
         if (in_kind) begin
            now_in = now_ff + epm_pkg::TIME_W'(1);
         end else begin
            sum_in   = sum_ff + epm_pkg::SUM_W'(in_raw);
            taken_in = taken_next[epm_pkg::TAKEN_W-1:0];
         end
      end
      if (cmd.mul) begin
         sum_in   = '0;
         taken_in = '0;
      end
      if (cmd.eval) begin
         if (edge_c) begin
            led_in      = !led_ff;
            edge_cnt_in = done_c ? '0 : edge_cnt_inc;
         end
         if (done_c) begin
            last_cnt_in  = now_ff;
            have_prev_in = 1'b1;
         end
         if (!in_band) begin
            last_out_in = mv_c;
         end
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         taken_ff     <= '0;
         last_out_ff  <= '0;
         edge_cnt_ff  <= '0;
         now_ff       <= '0;
         last_cnt_ff  <= '0;
         have_prev_ff <= 1'b0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         taken_ff     <= taken_in;
         last_out_ff  <= last_out_in;
         edge_cnt_ff  <= edge_cnt_in;
         now_ff       <= now_in;
         last_cnt_ff  <= last_cnt_in;
         have_prev_ff <= have_prev_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operand, result and output payload registers
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         num_ff <= epm_pkg::DIV_W'(sum_ff) * epm_pkg::DIV_W'(epm_pkg::MV_FULL_SCALE);
         den_ff <= epm_pkg::DIV_W'(n_eff) * epm_pkg::DIV_W'(epm_pkg::ADC_COUNTS);
      end
      if (cmd.eval) begin
         mv_ff      <= mv_c;
         edge_ff    <= edge_c;
         done_ff    <= done_c;
         pvalid_ff  <= done_c && have_prev_ff;
         energy_ff  <= done_c ? cfg.wh_per_count : '0;
         // zero interval saturates; a real quotient replaces this later
         power_ff   <= (done_c && have_prev_ff) ? '1 : '0;
         pw_num_ff  <= epm_pkg::DIV_W'(cfg.wh_per_count) *
                       epm_pkg::DIV_W'(epm_pkg::MS_PER_HOUR);
         elapsed_ff <= elapsed_c;
      end
      if (cmd.pw_store) begin
         power_ff <= div_quo;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {{epm_pkg::RSP_PAD{1'b0}}, power_ff, pvalid_ff, energy_ff,
                         done_ff, led_ff, edge_ff, mv_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a reading never exceeds the millivolt field
   a_mv_range: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> (div_quo[epm_pkg::DIV_W-1:epm_pkg::MV_W] == '0))
      else $error("millivolt quotient out of range");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

endmodule

[rtl/epm_ctrl.sv]
// ----------------------------------------------------------------------------
// Energy pulse meter controller
// Sequences accumulation, the two divisions and the result hand-off.
// ----------------------------------------------------------------------------
module epm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  epm_pkg::epm_sts_type  sts,
   output epm_pkg::epm_cmd_type  cmd
);

   epm_pkg::epm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= epm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == epm_pkg::ST_IDLE);
      case (state_ff)
         epm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (sts.reading_done) begin
                  state_in = epm_pkg::ST_MUL;
               end
            end
         end
         epm_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = epm_pkg::ST_MV_START;
         end
         epm_pkg::ST_MV_START: begin
            cmd.div_start = 1'b1;
            state_in      = epm_pkg::ST_MV_WAIT;
         end
         epm_pkg::ST_MV_WAIT: begin
            if (!sts.div_busy) begin
               state_in = epm_pkg::ST_EVAL;
            end
         end
         epm_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.power_div ? epm_pkg::ST_PW_START : epm_pkg::ST_OUT;
         end
         epm_pkg::ST_PW_START: begin
            cmd.div_start = 1'b1;
            cmd.div_pw    = 1'b1;
            state_in      = epm_pkg::ST_PW_WAIT;
         end
         epm_pkg::ST_PW_WAIT: begin
            cmd.div_pw = 1'b1;
            if (!sts.div_busy) begin
               cmd.pw_store = 1'b1;
               state_in     = epm_pkg::ST_OUT;
            end
         end
         epm_pkg::ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = epm_pkg::ST_IDLE;
            end
         end
         default: state_in = epm_pkg::ST_IDLE;
      endcase
   end

   // the divider is only launched when free
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider launched while busy");

endmodule

[rtl/energy_pulse_meter.sv]
// ----------------------------------------------------------------------------
// Energy pulse meter
// Pulse counter for an optical energy meter with hysteresis edge detection.
// ----------------------------------------------------------------------------
// Words arrive one at a time: a tick or an ADC sample that does not complete a
// reading is taken while the controller stays idle; the sample that completes
// a reading holds the input while the bit-serial divider forms the millivolt
// value, and while the same divider also forms the power when an energy count
// with a known interval needs it. A result word waits in its own register, so
// the input is open again while that word is still waiting to be taken.
module energy_pulse_meter (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [epm_pkg::REQ_W-1:0]   req_tdata,  // [9:0] raw_sample
   input  logic [0:0]                  req_tuser,  // [0] kind
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [12:0] millivolts, [13] edge_seen, [14] led_on, [15] count_done,
   // [25:16] energy_wh, [26] power_valid, [58:27] power_wph
   output logic [epm_pkg::RSP_W-1:0]   rsp_tdata,
   // configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [epm_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [epm_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [epm_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   epm_pkg::epm_cfg_type cfg;
   epm_pkg::epm_cmd_type cmd;
   epm_pkg::epm_sts_type sts;

   epm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   epm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   epm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sts        (sts),
      .in_kind    (req_tuser[0]),
      .in_raw     (req_tdata[epm_pkg::ADC_W-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
